// ----- rtl/core/edge_list_to_csr_builder_core_assert.svh -----
// assertion macros for the edge list to csr builder core
// no dependencies; define NO_ASSERTIONS to drop every check
`ifndef EDGE_LIST_TO_CSR_BUILDER_CORE_ASSERT_SVH
`define EDGE_LIST_TO_CSR_BUILDER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ELCSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("elcsr check failed");
// next-cycle implication
`define ELCSR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("elcsr check failed");
`else
`define ELCSR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ELCSR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/elcsr_pkg.sv -----
// shared types and constants of the edge list to csr builder
// no dependencies
package elcsr_pkg;

   localparam int VTX_W      = 10;
   localparam int WORD_W     = 13;
   localparam int DEG_W      = 11;
   localparam int NV_W       = 11;
   localparam int STATUS_W   = 2;
   localparam int ROW_BITS   = 32;
   localparam int ROW_SEL_W  = 5;
   localparam int BIT_SEL_W  = 5;
   localparam int EDGE_W     = 2 * VTX_W;

   localparam logic [NV_W-1:0] NV_RESET = 11'd1024;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_DATA = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD       = 2'd0,
      KIND_BUILD      = 2'd1,
      KIND_READ_WORD  = 2'd2,
      KIND_READ_START = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [VTX_W-1:0]    source;
      logic [VTX_W-1:0]    target;
      logic [WORD_W-1:0]   word_address;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   data;
      logic [WORD_W-1:0]   unique_edges;
      logic [DEG_W-1:0]    max_degree;
      logic [WORD_W-1:0]   total_words;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_CSR,
      SEL_START,
      SEL_LAST
   } rsp_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_E_RD,
      ST_E_BM,
      ST_E_WR,
      ST_V_START,
      ST_W_RD,
      ST_W_LOAD,
      ST_W_BITS,
      ST_V_END,
      ST_FIN
   } state_type;

   // index of the lowest set bit
   function automatic logic [BIT_SEL_W-1:0] lowest_set(input logic [ROW_BITS-1:0] bits);
      logic [BIT_SEL_W-1:0] pos;
      pos = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (bits[i]) pos = BIT_SEL_W'(i);
      end
      return pos;
   endfunction

endpackage

// ----- rtl/core/elcsr_bitmap.sv -----
// adjacency bitmap memory, one row of 32-bit words per vertex
// clears itself after reset; uses elcsr_pkg
module elcsr_bitmap #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic [elcsr_pkg::ROW_BITS-1:0]   rd_data,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic [elcsr_pkg::ROW_BITS-1:0]   wr_data,
   output logic                             ready
);

   logic [elcsr_pkg::ROW_BITS-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] clr_in;
   logic              ready_ff;
   logic              ready_in;
   logic              we;
   logic [ADDR_W-1:0] wa;
   logic [elcsr_pkg::ROW_BITS-1:0] wd;

   always_comb begin
      clr_in   = clr_ff;
      ready_in = ready_ff;
      if (!ready_ff) begin
         clr_in = ADDR_W'(clr_ff + 1'b1);
         if (32'(clr_ff) == DEPTH - 1) ready_in = 1'b1;
      end
      we = ready_ff ? wr_en : 1'b1;
      wa = ready_ff ? wr_addr : clr_ff;
      wd = ready_ff ? wr_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         ready_ff <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) rd_data <= mem[rd_addr];
   end

   assign ready = ready_ff;

endmodule

// ----- rtl/core/edge_list_to_csr_builder_core.sv -----
// Loads, word reads and start reads: result in the cycle after acceptance, one transaction per
// cycle while busy is low. Build: each stored edge passes E_RD, E_BM and E_WR; then each vertex
// below the count passes V_START, W_RD, W_LOAD and W_BITS for each of the 32 bitmap words of its
// row, one more W_BITS per unique edge, and V_END; then FIN, and then the result strobe.
// Reset is synchronous; afterwards busy stays high while the adjacency bitmap is cleared.
// Results are strobed for one cycle and cannot be stalled.
// uses elcsr_pkg, elcsr_bitmap and edge_list_to_csr_builder_core_assert.svh
`include "edge_list_to_csr_builder_core_assert.svh"
module edge_list_to_csr_builder_core #(
   parameter int MAX_EDGES    = 4096,
   parameter int MAX_VERTICES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  elcsr_pkg::req_type            req_item,
   output logic                          rsp_strobe,
   output elcsr_pkg::rsp_type            rsp_item,
   input  logic                          csr_wr_en,
   input  logic [elcsr_pkg::NV_W-1:0]    csr_wr_data
);

   localparam int WORD_CAP = MAX_EDGES + MAX_VERTICES + 1;
   localparam int VW = $clog2(MAX_VERTICES + 1);
   localparam int VA = $clog2(MAX_VERTICES);
   localparam int EA = $clog2(MAX_EDGES);
   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam int WA = $clog2(WORD_CAP);
   localparam int WC = $clog2(WORD_CAP + 1);
   localparam int BA = VA + elcsr_pkg::ROW_SEL_W;
   localparam int BM_DEPTH = MAX_VERTICES * elcsr_pkg::ROW_BITS;

   localparam int RW = elcsr_pkg::ROW_BITS;
   localparam int WW = elcsr_pkg::WORD_W;
   localparam int DW = elcsr_pkg::DEG_W;
   localparam int XW = elcsr_pkg::EDGE_W;
   localparam int TW = elcsr_pkg::VTX_W;
   localparam int SW = elcsr_pkg::ROW_SEL_W;

   // memories
   logic [XW-1:0] edge_mem [MAX_EDGES];
   logic [WW-1:0] word_mem [WORD_CAP];
   logic [WW-1:0] start_mem [MAX_VERTICES];

   logic          e_we, e_re;
   logic [EA-1:0] e_waddr, e_raddr;
   logic [XW-1:0] e_wdata, e_q;
   logic          c_we, c_re;
   logic [WA-1:0] c_waddr, c_raddr;
   logic [WW-1:0] c_wdata, c_q;
   logic          v_we, v_re;
   logic [VA-1:0] v_waddr, v_raddr;
   logic [WW-1:0] v_wdata, v_q;
   logic          bm_re, bm_we, bm_ready;
   logic [BA-1:0] bm_raddr, bm_waddr;
   logic [RW-1:0] bm_wdata, bm_q;

   elcsr_pkg::state_type   state_ff, state_in;
   logic [elcsr_pkg::NV_W-1:0] nv_ff, nv_in;
   logic [EW-1:0]          loaded_ff, loaded_in;
   logic                   built_ff, built_in;
   logic [VW-1:0]          built_v_ff, built_v_in;
   logic [VW-1:0]          nv_eff_ff, nv_eff_in;
   logic [WW-1:0]          edge_total_ff, edge_total_in;
   logic [DW-1:0]          peak_ff, peak_in;
   logic [WC-1:0]          word_total_ff, word_total_in;
   logic [EW-1:0]          idx_ff, idx_in;
   logic                   skip_ff, skip_in;
   logic [BA-1:0]          bm_addr_ff, bm_addr_in;
   logic [elcsr_pkg::BIT_SEL_W-1:0] bit_ff, bit_in;
   logic [VW-1:0]          v_ff, v_in;
   logic [SW-1:0]          j_ff, j_in;
   logic [RW-1:0]          bits_ff, bits_in;
   logic [WC-1:0]          head_ff, head_in;
   logic [WC-1:0]          wptr_ff, wptr_in;
   logic [WC-1:0]          w_ff, w_in;
   logic [DW-1:0]          deg_ff, deg_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   elcsr_pkg::rsp_sel_type rsp_sel_ff, rsp_sel_in;
   logic [elcsr_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic [VW-1:0]          nv_cap;
   logic [TW-1:0]          e_src, e_tgt;
   logic [elcsr_pkg::BIT_SEL_W-1:0] low_pos;

   assign accept = start && !busy;
   assign busy   = (state_ff != elcsr_pkg::ST_IDLE);
   assign e_src  = e_q[XW-1:TW];
   assign e_tgt  = e_q[TW-1:0];
   assign low_pos = elcsr_pkg::lowest_set(bits_ff);
   assign nv_cap = (32'(nv_ff) > MAX_VERTICES) ? VW'(MAX_VERTICES) : VW'(nv_ff);

   elcsr_bitmap #(
      .DEPTH  (BM_DEPTH),
      .ADDR_W (BA)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (bm_re),
      .rd_addr (bm_raddr),
      .rd_data (bm_q),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .ready   (bm_ready)
   );

   always_comb begin
      state_in      = state_ff;
      nv_in         = csr_wr_en ? csr_wr_data : nv_ff;
      loaded_in     = loaded_ff;
      built_in      = built_ff;
      built_v_in    = built_v_ff;
      nv_eff_in     = nv_eff_ff;
      edge_total_in = edge_total_ff;
      peak_in       = peak_ff;
      word_total_in = word_total_ff;
      idx_in        = idx_ff;
      skip_in       = skip_ff;
      bm_addr_in    = bm_addr_ff;
      bit_in        = bit_ff;
      v_in          = v_ff;
      j_in          = j_ff;
      bits_in       = bits_ff;
      head_in       = head_ff;
      wptr_in       = wptr_ff;
      w_in          = w_ff;
      deg_in        = deg_ff;
      rsp_strobe_in = 1'b0;
      rsp_sel_in    = rsp_sel_ff;
      rsp_status_in = rsp_status_ff;
      e_we = 1'b0; e_waddr = EA'(loaded_ff); e_wdata = {req_item.source, req_item.target};
      e_re = 1'b0; e_raddr = EA'(idx_ff);
      c_we = 1'b0; c_waddr = WA'(wptr_ff); c_wdata = '0;
      c_re = 1'b0; c_raddr = WA'(req_item.word_address);
      v_we = 1'b0; v_waddr = VA'(v_ff); v_wdata = WW'(w_ff);
      v_re = 1'b0; v_raddr = VA'(req_item.source);
      bm_re = 1'b0; bm_raddr = {VA'(v_ff), j_ff};
      bm_we = 1'b0; bm_waddr = bm_addr_ff; bm_wdata = '0;

      unique case (state_ff)
         elcsr_pkg::ST_CLEAR: begin
            if (bm_ready) state_in = elcsr_pkg::ST_IDLE;
         end
         elcsr_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_sel_in    = elcsr_pkg::SEL_ZERO;
               rsp_status_in = elcsr_pkg::STATUS_OK;
               unique case (req_item.kind)
                  elcsr_pkg::KIND_LOAD: begin
                     rsp_strobe_in = 1'b1;
                     if (32'(loaded_ff) < MAX_EDGES) begin
                        e_we      = 1'b1;
                        loaded_in = EW'(loaded_ff + 1'b1);
                     end else begin
                        rsp_status_in = elcsr_pkg::STATUS_FULL;
                     end
                  end
                  elcsr_pkg::KIND_BUILD: begin
                     nv_eff_in     = nv_cap;
                     edge_total_in = '0;
                     peak_in       = '0;
                     idx_in        = '0;
                     v_in          = '0;
                     w_in          = '0;
                     state_in = (loaded_ff == '0) ? elcsr_pkg::ST_V_START
                                                  : elcsr_pkg::ST_E_RD;
                  end
                  elcsr_pkg::KIND_READ_WORD: begin
                     rsp_strobe_in = 1'b1;
                     if (!built_ff ||
                         32'(req_item.word_address) >= 32'(word_total_ff)) begin
                        rsp_status_in = elcsr_pkg::STATUS_NO_DATA;
                     end else begin
                        c_re       = 1'b1;
                        rsp_sel_in = elcsr_pkg::SEL_CSR;
                     end
                  end
                  elcsr_pkg::KIND_READ_START: begin
                     rsp_strobe_in = 1'b1;
                     if (!built_ff) begin
                        rsp_status_in = elcsr_pkg::STATUS_NO_DATA;
                     end else if (32'(req_item.source) < 32'(built_v_ff)) begin
                        v_re       = 1'b1;
                        rsp_sel_in = elcsr_pkg::SEL_START;
                     end else begin
                        rsp_sel_in = elcsr_pkg::SEL_LAST;
                     end
                  end
                  default: ;
               endcase
            end
         end
         elcsr_pkg::ST_E_RD: begin
            e_re     = 1'b1;
            state_in = elcsr_pkg::ST_E_BM;
         end
         elcsr_pkg::ST_E_BM: begin
            // edges past the vertex count never reach the bitmap
            skip_in    = (32'(e_src) >= 32'(nv_eff_ff));
            bm_addr_in = {VA'(e_src), e_tgt[TW-1:TW-SW]};
            bit_in     = e_tgt[elcsr_pkg::BIT_SEL_W-1:0];
            bm_re      = 1'b1;
            bm_raddr   = {VA'(e_src), e_tgt[TW-1:TW-SW]};
            state_in   = elcsr_pkg::ST_E_WR;
         end
         elcsr_pkg::ST_E_WR: begin
            bm_we    = !skip_ff;
            bm_wdata = bm_q | (RW'(1) << bit_ff);
            idx_in   = EW'(idx_ff + 1'b1);
            state_in = (EW'(idx_ff + 1'b1) == loaded_ff) ? elcsr_pkg::ST_V_START
                                                         : elcsr_pkg::ST_E_RD;
         end
         elcsr_pkg::ST_V_START: begin
            if (v_ff == nv_eff_ff) begin
               state_in = elcsr_pkg::ST_FIN;
            end else begin
               v_we     = 1'b1;
               head_in  = w_ff;
               wptr_in  = WC'(w_ff + 1'b1);
               deg_in   = '0;
               j_in     = '0;
               state_in = elcsr_pkg::ST_W_RD;
            end
         end
         elcsr_pkg::ST_W_RD: begin
            bm_re    = 1'b1;
            state_in = elcsr_pkg::ST_W_LOAD;
         end
         elcsr_pkg::ST_W_LOAD: begin
            // read word is consumed and cleared for the next build
            bits_in  = bm_q;
            bm_we    = 1'b1;
            bm_waddr = {VA'(v_ff), j_ff};
            state_in = elcsr_pkg::ST_W_BITS;
         end
         elcsr_pkg::ST_W_BITS: begin
            if (bits_ff != '0) begin
               c_we    = 1'b1;
               c_wdata = WW'({j_ff, low_pos});
               wptr_in = WC'(wptr_ff + 1'b1);
               deg_in  = DW'(deg_ff + 1'b1);
               bits_in = bits_ff & (bits_ff - 1'b1);
            end else begin
               j_in     = SW'(j_ff + 1'b1);
               state_in = (j_ff == '1) ? elcsr_pkg::ST_V_END : elcsr_pkg::ST_W_RD;
            end
         end
         elcsr_pkg::ST_V_END: begin
            c_we          = 1'b1;
            c_waddr       = WA'(head_ff);
            c_wdata       = WW'(deg_ff);
            w_in          = wptr_ff;
            edge_total_in = WW'(edge_total_ff + WW'(deg_ff));
            if (deg_ff > peak_ff) peak_in = deg_ff;
            v_in          = VW'(v_ff + 1'b1);
            state_in      = elcsr_pkg::ST_V_START;
         end
         elcsr_pkg::ST_FIN: begin
            c_we          = 1'b1;
            c_waddr       = WA'(w_ff);
            c_wdata       = '0;
            word_total_in = WC'(w_ff + 1'b1);
            built_in      = 1'b1;
            built_v_in    = nv_eff_ff;
            rsp_strobe_in = 1'b1;
            rsp_sel_in    = elcsr_pkg::SEL_ZERO;
            rsp_status_in = elcsr_pkg::STATUS_OK;
            state_in      = elcsr_pkg::ST_IDLE;
         end
         default: state_in = elcsr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= elcsr_pkg::ST_CLEAR;
         nv_ff         <= elcsr_pkg::NV_RESET;
         loaded_ff     <= '0;
         built_ff      <= 1'b0;
         built_v_ff    <= '0;
         edge_total_ff <= '0;
         peak_ff       <= '0;
         word_total_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nv_ff         <= nv_in;
         loaded_ff     <= loaded_in;
         built_ff      <= built_in;
         built_v_ff    <= built_v_in;
         edge_total_ff <= edge_total_in;
         peak_ff       <= peak_in;
         word_total_ff <= word_total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      nv_eff_ff     <= nv_eff_in;
      idx_ff        <= idx_in;
      skip_ff       <= skip_in;
      bm_addr_ff    <= bm_addr_in;
      bit_ff        <= bit_in;
      v_ff          <= v_in;
      j_ff          <= j_in;
      bits_ff       <= bits_in;
      head_ff       <= head_in;
      wptr_ff       <= wptr_in;
      w_ff          <= w_in;
      deg_ff        <= deg_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (e_we) edge_mem[e_waddr] <= e_wdata;
      if (e_re) e_q <= edge_mem[e_raddr];
   end

   always_ff @(posedge clock) begin
      if (c_we) word_mem[c_waddr] <= c_wdata;
      if (c_re) c_q <= word_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) start_mem[v_waddr] <= v_wdata;
      if (v_re) v_q <= start_mem[v_raddr];
   end

   always_comb begin
      unique case (rsp_sel_ff)
         elcsr_pkg::SEL_CSR:   rsp_item.data = c_q;
         elcsr_pkg::SEL_START: rsp_item.data = v_q;
         elcsr_pkg::SEL_LAST:  rsp_item.data = WW'(word_total_ff - 1'b1);
         default:              rsp_item.data = '0;
      endcase
      rsp_item.unique_edges = edge_total_ff;
      rsp_item.max_degree   = peak_ff;
      rsp_item.total_words  = WW'(word_total_ff);
      rsp_item.status       = rsp_status_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;

   `ELCSR_ASSERT_NXT(a_quick_rsp, clock, reset, accept && req_item.kind != elcsr_pkg::KIND_BUILD, rsp_strobe)
   `ELCSR_ASSERT_IMP(a_full_drop, clock, reset, rsp_strobe && rsp_item.status == elcsr_pkg::STATUS_FULL, 32'(loaded_ff) == MAX_EDGES)
   `ELCSR_ASSERT_IMP(a_built_words, clock, reset, built_ff, word_total_ff != '0)

endmodule

// ----- tb/tb.sv -----
// testbench for the edge list to csr builder core: directed and random transactions
// checked against an in-bench model of the edge store and the built csr array
// depends on elcsr_pkg and edge_list_to_csr_builder_core
`timescale 1ns / 100ps
module tb;

   localparam int EDGE_CAP   = 4096;
   localparam int VTX_CAP    = 1024;
   localparam int WORD_CAP   = EDGE_CAP + VTX_CAP + 1;
   localparam int CYCLE_CAP  = 4000000;
   localparam int SHOW_ERRS  = 10;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   elcsr_pkg::req_type             req_item;
   logic                           rsp_strobe;
   elcsr_pkg::rsp_type             rsp_item;
   logic                           csr_wr_en;
   logic [elcsr_pkg::NV_W-1:0]     csr_wr_data;

   edge_list_to_csr_builder_core #(
      .MAX_EDGES(EDGE_CAP),
      .MAX_VERTICES(VTX_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // graph model state
   logic [elcsr_pkg::VTX_W-1:0]    edge_src [EDGE_CAP];
   logic [elcsr_pkg::VTX_W-1:0]    edge_tgt [EDGE_CAP];
   int                             edges_held;
   logic [elcsr_pkg::WORD_W-1:0]   csr_mem [WORD_CAP];
   logic [elcsr_pkg::WORD_W-1:0]   vtx_offset [VTX_CAP];
   int                             uniq_count;
   int                             deg_peak;
   int                             word_count;
   bit                             is_built;
   int                             built_nv;
   int                             nv_setting;

   elcsr_pkg::rsp_type             pending_rsp [$];
   int                             err_count;
   int                             cycle_count;
   int                             burst_left;
   int                             n_loads, n_builds, n_reads, n_dropped;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d transactions outstanding",
                  cycle_count, pending_rsp.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // sort the edges below the vertex count and lay out the csr array
   task automatic build_graph();
      int keys [$];
      int nv, k, w, head, deg, last, t;
      nv = (nv_setting > VTX_CAP) ? VTX_CAP : nv_setting;
      for (int i = 0; i < edges_held; i++)
         if (edge_src[i] < nv) keys.push_back(edge_src[i] * VTX_CAP + edge_tgt[i]);
      keys.sort();
      k = 0;
      w = 0;
      uniq_count = 0;
      deg_peak = 0;
      for (int v = 0; v < nv; v++) begin
         vtx_offset[v] = w;
         if (k >= keys.size() || (keys[k] / VTX_CAP) != v) begin
            csr_mem[w] = '0;
            w++;
         end else begin
            head = w;
            w++;
            deg = 0;
            last = -1;
            while (k < keys.size() && (keys[k] / VTX_CAP) == v) begin
               t = keys[k] % VTX_CAP;
               if (t != last) begin
                  csr_mem[w] = t;
                  w++;
                  deg++;
                  last = t;
               end
               k++;
            end
            csr_mem[head] = deg;
            uniq_count += deg;
            if (deg > deg_peak) deg_peak = deg;
         end
      end
      csr_mem[w] = '0;
      word_count = w + 1;
      built_nv = nv;
      is_built = 1'b1;
   endtask

   task automatic csr_predict(input elcsr_pkg::req_type it, output elcsr_pkg::rsp_type r);
      r = '0;
      case (it.kind)
         elcsr_pkg::KIND_LOAD: begin
            n_loads++;
            if (edges_held < EDGE_CAP) begin
               edge_src[edges_held] = it.source;
               edge_tgt[edges_held] = it.target;
               edges_held++;
            end else begin
               r.status = elcsr_pkg::STATUS_FULL;
               n_dropped++;
            end
         end
         elcsr_pkg::KIND_BUILD: begin
            n_builds++;
            build_graph();
         end
         elcsr_pkg::KIND_READ_WORD: begin
            n_reads++;
            if (!is_built || it.word_address >= word_count)
               r.status = elcsr_pkg::STATUS_NO_DATA;
            else r.data = csr_mem[it.word_address];
         end
         default: begin
            n_reads++;
            if (!is_built) r.status = elcsr_pkg::STATUS_NO_DATA;
            else if (it.source < built_nv) r.data = vtx_offset[it.source];
            else r.data = word_count - 1;
         end
      endcase
      r.unique_edges = uniq_count;
      r.max_degree = deg_peak;
      r.total_words = word_count;
   endtask

   // result checker
   always @(posedge clock) begin
      elcsr_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            err_count++;
            if (err_count <= SHOW_ERRS) $display("unexpected result %p", rsp_item);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.data !== want.data || rsp_item.unique_edges !== want.unique_edges ||
                rsp_item.max_degree !== want.max_degree ||
                rsp_item.total_words !== want.total_words ||
                rsp_item.status !== want.status) begin
               err_count++;
               if (err_count <= SHOW_ERRS)
                  $display({"mismatch: expected data %0d uniq %0d peak %0d words %0d st %0d,",
                            " got data %0d uniq %0d peak %0d words %0d st %0d"},
                           want.data, want.unique_edges, want.max_degree, want.total_words,
                           want.status, rsp_item.data, rsp_item.unique_edges,
                           rsp_item.max_degree, rsp_item.total_words, rsp_item.status);
            end
         end
      end
   end

   // one transaction; start stays high within a burst
   task automatic send_item(input elcsr_pkg::req_type it);
      elcsr_pkg::rsp_type r;
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      csr_predict(it, r);
      pending_rsp.push_back(r);
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 80);
         else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   function automatic elcsr_pkg::req_type make_req(input elcsr_pkg::kind_type k, input int s,
                                                   input int t, input int a);
      elcsr_pkg::req_type it;
      it.kind = k;
      it.source = s;
      it.target = t;
      it.word_address = a;
      return it;
   endfunction

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_vertices(input int nv);
      csr_wr_en <= 1'b1;
      csr_wr_data <= nv;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      nv_setting = nv;
   endtask

   task automatic send_build_and_scan();
      send_item(make_req(elcsr_pkg::KIND_BUILD, $urandom, $urandom, $urandom));
      send_item(make_req(elcsr_pkg::KIND_READ_WORD, 0, 0, 0));
      send_item(make_req(elcsr_pkg::KIND_READ_WORD, 0, 0, word_count - 1));
      send_item(make_req(elcsr_pkg::KIND_READ_WORD, 0, 0, word_count));
      send_item(make_req(elcsr_pkg::KIND_READ_WORD, 0, 0, 8191));
      send_item(make_req(elcsr_pkg::KIND_READ_START, 0, 0, 0));
      send_item(make_req(elcsr_pkg::KIND_READ_START, 1023, 0, 0));
   endtask

   task automatic test_read_before_build();
      send_item(make_req(elcsr_pkg::KIND_READ_WORD, 0, 0, 0));
      send_item(make_req(elcsr_pkg::KIND_READ_START, 5, 0, 8191));
      drain();
   endtask

   task automatic test_directed();
      send_item(make_req(elcsr_pkg::KIND_LOAD, 0, 0, 0));
      send_item(make_req(elcsr_pkg::KIND_LOAD, 0, 1023, 8191));
      send_item(make_req(elcsr_pkg::KIND_LOAD, 0, 0, 0));
      send_item(make_req(elcsr_pkg::KIND_LOAD, 1023, 1023, 0));
      send_item(make_req(elcsr_pkg::KIND_LOAD, 3, 7, 0));
      send_item(make_req(elcsr_pkg::KIND_LOAD, 3, 2, 0));
      send_item(make_req(elcsr_pkg::KIND_LOAD, 3, 7, 0));
      send_build_and_scan();
      send_item(make_req(elcsr_pkg::KIND_READ_START, 3, 0, 0));
      send_item(make_req(elcsr_pkg::KIND_READ_WORD, 0, 0, 1030));
      drain();
      // zero vertices: only the closing word
      set_vertices(0);
      send_build_and_scan();
      drain();
      // above the vertex limit acts as the limit
      set_vertices(2047);
      send_build_and_scan();
      drain();
   endtask

   task automatic test_random(input int count);
      int nv, span, r;
      for (int p = 0; p < count / 150; p++) begin
         r = $urandom_range(0, 5);
         nv = (r == 0) ? 1 : (r == 1) ? 2 : $urandom_range(3, 48);
         set_vertices(nv);
         for (int i = 0; i < 150; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               send_item(make_req(elcsr_pkg::KIND_LOAD,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(0, nv - 1)
                                              : $urandom_range(0, 1023),
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023),
                  $urandom));
            end else if (r < 48) begin
               send_item(make_req(elcsr_pkg::KIND_BUILD, $urandom, $urandom, $urandom));
            end else if (r < 75) begin
               span = is_built ? word_count + 2 : 4;
               send_item(make_req(elcsr_pkg::KIND_READ_WORD, $urandom, $urandom,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(0, span)
                                              : $urandom_range(0, 8191)));
            end else begin
               send_item(make_req(elcsr_pkg::KIND_READ_START,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(0, nv + 2)
                                              : $urandom_range(0, 1023),
                  $urandom, $urandom));
            end
            // hold off now and then until everything has come back
            if ($urandom_range(0, 99) == 0) drain();
         end
         drain();
      end
   endtask

   task automatic test_store_full();
      set_vertices(40);
      while (edges_held < EDGE_CAP)
         send_item(make_req(elcsr_pkg::KIND_LOAD, $urandom_range(0, 60), $urandom, $urandom));
      for (int i = 0; i < 6; i++)
         send_item(make_req(elcsr_pkg::KIND_LOAD, $urandom, $urandom, $urandom));
      send_build_and_scan();
      for (int i = 0; i < 40; i++)
         send_item(make_req(elcsr_pkg::KIND_READ_WORD, 0, 0, $urandom_range(0, word_count)));
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cycle_count = 0;
      err_count = 0;
      edges_held = 0;
      uniq_count = 0;
      deg_peak = 0;
      word_count = 0;
      is_built = 1'b0;
      built_nv = 0;
      nv_setting = elcsr_pkg::NV_RESET;
      burst_left = 5;
      n_loads = 0;
      n_builds = 0;
      n_reads = 0;
      n_dropped = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
      test_read_before_build();
      test_directed();
      test_random(1750);
      test_store_full();
      drain();
      if (pending_rsp.size() != 0) err_count++;
      $display("covered %0d edge loads (%0d dropped when full), %0d builds, %0d reads",
               n_loads, n_dropped, n_builds, n_reads);
      $display("vertex counts 0, 1, 2, 3..48 and above the limit, in %0d cycles", cycle_count);
      if (err_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
